### rtl/kdlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdlp_pkg: shared definitions for the key debouncer
// Event codes, field widths and the long press period reset value.
// ----------------------------------------------------------------------------
package kdlp_pkg;

    // Field widths
    localparam int unsigned EVENT_W  = 3;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned KEYS_N   = 4;

    // Default long press period in held ticks
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'h6fff;

    // Event codes; key codes 1..4 share the same values
    localparam logic [EVENT_W-1:0] EV_NONE      = 3'd0;
    localparam logic [EVENT_W-1:0] EV_PAUSE     = 3'd1;
    localparam logic [EVENT_W-1:0] EV_PLUS      = 3'd2;
    localparam logic [EVENT_W-1:0] EV_MINUS     = 3'd3;
    localparam logic [EVENT_W-1:0] EV_MOVE      = 3'd4;
    localparam logic [EVENT_W-1:0] EV_MOVE_LONG = 3'd5;

    typedef logic [EVENT_W-1:0] event_t;

    // Priority encoder, pause/start highest; levels are active low
    function automatic event_t encode_keys(input logic [KEYS_N-1:0] keys_n);
        event_t code;
        code = EV_NONE;
        if (!keys_n[0])
        begin
            code = EV_PAUSE;
        end
        else if (!keys_n[1])
        begin
            code = EV_PLUS;
        end
        else if (!keys_n[2])
        begin
            code = EV_MINUS;
        end
        else if (!keys_n[3])
        begin
            code = EV_MOVE;
        end
        return code;
    endfunction

endpackage

### rtl/key_debounce_long_press.sv
`timescale 1ns / 1ps
// An accepted request reaches m_axis through the input register, then the
// result register, and waits there while m_axis_tready is low.
// Throughput: one request per cycle unless a low m_axis_tready stalls the
// result register; the press state advances as each registered sample moves into the result register.
// Reset: rst_n clears phase, latched key, hold count, both valid flags and
// restores long_press_period to 0x6fff.
// ----------------------------------------------------------------------------
// key_debounce_long_press: four-key debouncer with long press detection
// Each request is one scan tick of four active-low key levels; each tick
// yields one event code.
// ----------------------------------------------------------------------------
module key_debounce_long_press
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: long_press_period
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // scan ticks in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [0] key_pause_n, [1] key_plus_n,
                                       // [2] key_minus_n, [3] key_move_n, [7:4] 0
    // events out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // [2:0] key_event, [7:3] 0
);

    // Phase codes
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_WOBBLE   = 3'd1;
    localparam logic [2:0] PH_PRESS    = 3'd2;
    localparam logic [2:0] PH_LONG     = 3'd3;
    localparam logic [2:0] PH_CONTINUE = 3'd4;
    localparam logic [2:0] PH_RELEASE  = 3'd5;

    logic [kdlp_pkg::PERIOD_W-1:0] period_reg;

    logic                        in_valid_reg;
    logic [kdlp_pkg::KEYS_N-1:0] in_keys_reg;

    logic            out_valid_reg;
    kdlp_pkg::event_t out_event_reg;

    logic [2:0]                    phase_reg,  phase_next;
    kdlp_pkg::event_t              held_reg,   held_next;
    logic [kdlp_pkg::PERIOD_W-1:0] count_reg,  count_next;
    kdlp_pkg::event_t              event_next;

    kdlp_pkg::event_t              key;
    logic                          down;
    logic [kdlp_pkg::PERIOD_W-1:0] count_inc;
    logic                          advance;

    // Handshake: stage moves when the result register is free or drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_event_reg};

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= kdlp_pkg::PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            period_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_keys_reg <= s_axis_tdata[kdlp_pkg::KEYS_N-1:0];
        end
    end

    // Press state machine
    always_comb
    begin
        key        = kdlp_pkg::encode_keys(in_keys_reg);
        down       = (key != kdlp_pkg::EV_NONE);
        count_inc  = count_reg + 16'd1;
        phase_next = phase_reg;
        held_next  = held_reg;
        count_next = count_reg;
        event_next = kdlp_pkg::EV_NONE;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (down)
                begin
                    phase_next = PH_WOBBLE;
                end
            end
            PH_WOBBLE:
            begin
                phase_next = PH_PRESS;
            end
            PH_PRESS:
            begin
                if (down)
                begin
                    held_next  = key;
                    phase_next = PH_LONG;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_LONG:
            begin
                if (down)
                begin
                    count_next = count_inc;
                    if (count_inc > period_reg)
                    begin
                        count_next = '0;
                        phase_next = PH_CONTINUE;
                    end
                end
                else
                begin
                    count_next = '0;
                    phase_next = PH_RELEASE;
                end
            end
            PH_CONTINUE:
            begin
                if (down)
                begin
                    if (held_reg == kdlp_pkg::EV_MOVE)
                    begin
                        held_next  = kdlp_pkg::EV_NONE;
                        event_next = kdlp_pkg::EV_MOVE_LONG;
                    end
                end
                else
                begin
                    phase_next = PH_RELEASE;
                end
            end
            PH_RELEASE:
            begin
                event_next = held_reg;
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= kdlp_pkg::EV_NONE;
            count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_event_reg <= event_next;
        end
    end

    // Assertions
    a_count_only_long: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (phase_reg == PH_LONG))
        else $error("hold count nonzero outside long phase");

    a_event_source: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && event_next != kdlp_pkg::EV_NONE) |->
        (phase_reg == PH_RELEASE || phase_reg == PH_CONTINUE))
        else $error("event raised from a phase that emits none");

    a_move_long_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && event_next == kdlp_pkg::EV_MOVE_LONG) |=>
        (held_reg == kdlp_pkg::EV_NONE && phase_reg == PH_CONTINUE))
        else $error("latched key not cleared after move-long");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled with room in the pipeline");

endmodule
